FILE: rtl/core/ultrasonic_echo_ranger_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the ultrasonic echo ranger
// Concurrent checks clocked on the rising edge, held off during reset.
// ---------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

// same-cycle implication
`define UER_ASSERT_IMP(name, clk_i, rstn_i, ante, cons, msg) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UER_ASSERT_NXT(name, clk_i, rstn_i, ante, cons, msg) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/uer_pkg.sv
// ---------------------------------------------------------------------------
// uer_pkg
// Shared types, constants and helpers of the ultrasonic echo ranger.
// ---------------------------------------------------------------------------
package uer_pkg;

	// counter width of the phase and echo counters
	localparam int CNT_BITS = 16;
	localparam logic [CNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [CNT_BITS-1:0] CNT_ONE = CNT_BITS'(1);
	// width at which counters and timeout registers are compared
	localparam int CMP_BITS = (CNT_BITS > 16) ? CNT_BITS : 16;

	// configuration port
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam logic [CFG_IDX_BITS-1:0] REG_TRIG_LOW  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TRIG_HIGH = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_RISE_TO   = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_ECHO_TO   = 2'd3;

	localparam logic [7:0]  TRIG_LOW_RST  = 8'd8;
	localparam logic [7:0]  TRIG_HIGH_RST = 8'd20;
	localparam logic [15:0] RISE_TO_RST   = 16'd5000;
	localparam logic [15:0] ECHO_TO_RST   = 16'd29000;

	// distance: ticks / 58 by reciprocal multiply, exact for all counter values
	localparam int DIST_BITS = 10;
	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;
	localparam int CM_DIVISOR = 58;
	localparam int DIV_SHIFT  = CNT_BITS + 6;
	localparam int DIV_MUL    = ((2 ** DIV_SHIFT) + CM_DIVISOR - 1) / CM_DIVISOR;
	localparam int MUL_BITS   = CNT_BITS + 1;
	localparam int PROD_BITS  = CNT_BITS + MUL_BITS;
	localparam int QUO_BITS   = PROD_BITS - DIV_SHIFT;

	// queue depths
	localparam int QDEPTH     = 4;
	localparam int QPTR_BITS  = $clog2(QDEPTH);
	localparam int QCNT_BITS  = $clog2(QDEPTH + 1);
	localparam int OQ_DEPTH   = 2;
	localparam int OQPTR_BITS = $clog2(OQ_DEPTH);
	localparam int OQCNT_BITS = $clog2(OQ_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TRIG_LOW,
		PH_TRIG_HIGH,
		PH_WAIT_RISE,
		PH_ECHO
	} uer_phase_t;

	// word from the front FSM to the back end
	typedef struct packed {
		logic                trig;
		logic                busy;
		logic                done;
		logic                tmo;
		logic                upd;
		logic [CNT_BITS-1:0] ticks;
	} uer_cmd_t;

	// result word
	typedef struct packed {
		logic                 trig;
		logic                 busy;
		logic                 done;
		logic                 tmo;
		logic [DIST_BITS-1:0] dist_cm;
	} uer_res_t;

	function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
		return (v == CNT_MAX) ? v : v + CNT_ONE;
	endfunction

	function automatic logic [DIST_BITS-1:0] sat_dist(input logic [QUO_BITS-1:0] q);
		if (32'(q) > 32'(DIST_MAX)) begin
			return DIST_MAX;
		end
		return DIST_BITS'(q);
	endfunction

endpackage

FILE: rtl/core/uer_front.sv
// ---------------------------------------------------------------------------
// uer_front
// Tick-by-tick measurement sequencer: trigger pulse, rise wait, echo count.
// ---------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_macros.svh"

module uer_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic                               start_req,
	input  logic                               echo_level,
	input  logic                               cfg_we,
	input  logic [uer_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [uer_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output logic                               cmd_valid,
	output uer_pkg::uer_cmd_t                  cmd
);
	import uer_pkg::*;

	logic [7:0]          trig_low_q;
	logic [7:0]          trig_high_q;
	logic [15:0]         rise_to_q;
	logic [15:0]         echo_to_q;
	uer_phase_t          phase_q, phase_d;
	logic [CNT_BITS-1:0] phase_ticks_q, phase_ticks_d;
	logic [CNT_BITS-1:0] echo_ticks_q, echo_ticks_d;
	logic                done, tmo;
	logic [CNT_BITS-1:0] pt_inc, et_inc;
	logic [7:0]          high_eff;
	logic [15:0]         rise_eff;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_low_q  <= TRIG_LOW_RST;
			trig_high_q <= TRIG_HIGH_RST;
			rise_to_q   <= RISE_TO_RST;
			echo_to_q   <= ECHO_TO_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TRIG_LOW:  trig_low_q  <= cfg_data[7:0];
				REG_TRIG_HIGH: trig_high_q <= cfg_data[7:0];
				REG_RISE_TO:   rise_to_q   <= cfg_data;
				REG_ECHO_TO:   echo_to_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pt_inc   = sat_inc(phase_ticks_q);
	assign et_inc   = sat_inc(echo_ticks_q);
	assign high_eff = (trig_high_q == 8'd0) ? 8'd1 : trig_high_q;
	assign rise_eff = (rise_to_q == 16'd0) ? 16'd1 : rise_to_q;

	// next state
	always_comb begin
		phase_d       = phase_q;
		phase_ticks_d = phase_ticks_q;
		echo_ticks_d  = echo_ticks_q;
		done          = 1'b0;
		tmo           = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (start_req) begin
					phase_d       = (trig_low_q != 8'd0) ? PH_TRIG_LOW : PH_TRIG_HIGH;
					phase_ticks_d = CNT_ONE;
				end
			end
			PH_TRIG_LOW: begin
				if (CMP_BITS'(phase_ticks_q) >= CMP_BITS'(trig_low_q)) begin
					phase_d       = PH_TRIG_HIGH;
					phase_ticks_d = CNT_ONE;
				end else begin
					phase_ticks_d = pt_inc;
				end
			end
			PH_TRIG_HIGH: begin
				if (CMP_BITS'(phase_ticks_q) >= CMP_BITS'(high_eff)) begin
					phase_d       = PH_WAIT_RISE;
					phase_ticks_d = '0;
				end else begin
					phase_ticks_d = pt_inc;
				end
			end
			PH_WAIT_RISE: begin
				if (echo_level) begin
					phase_d      = PH_ECHO;
					echo_ticks_d = CNT_ONE;
					// zero echo timeout: the first high tick already expires
					if (echo_to_q == 16'd0) begin
						done = 1'b1;
						tmo  = 1'b1;
					end
				end else begin
					phase_ticks_d = pt_inc;
					if (CMP_BITS'(pt_inc) >= CMP_BITS'(rise_eff) || pt_inc == CNT_MAX) begin
						done = 1'b1;
						tmo  = 1'b1;
					end
				end
			end
			PH_ECHO: begin
				if (!echo_level) begin
					done = 1'b1;
				end else begin
					echo_ticks_d = et_inc;
					if (CMP_BITS'(et_inc) > CMP_BITS'(echo_to_q) || et_inc == CNT_MAX) begin
						done = 1'b1;
						tmo  = 1'b1;
					end
				end
			end
			default: phase_d = PH_IDLE;
		endcase
		if (done) begin
			phase_d = PH_IDLE;
		end
	end

	// outputs: the word for this tick
	always_comb begin
		cmd_valid = adv;
		cmd.trig  = (phase_d == PH_TRIG_HIGH);
		cmd.busy  = (phase_d != PH_IDLE);
		cmd.done  = done;
		cmd.tmo   = tmo;
		cmd.upd   = done & ~tmo;
		cmd.ticks = echo_ticks_q;
	end

	// advance one tick per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			phase_ticks_q <= '0;
			echo_ticks_q  <= '0;
		end else if (adv) begin
			phase_q       <= phase_d;
			phase_ticks_q <= phase_ticks_d;
			echo_ticks_q  <= echo_ticks_d;
		end
	end

	`UER_ASSERT_IMP(a_trig_busy, clk, arst_n, cmd_valid && cmd.trig, cmd.busy, "trigger high while not busy")
	`UER_ASSERT_IMP(a_done_idle, clk, arst_n, cmd_valid && cmd.done, !cmd.busy, "done word still busy")
	`UER_ASSERT_IMP(a_tmo_done, clk, arst_n, cmd_valid && cmd.tmo, cmd.done, "timeout without done")
	`UER_ASSERT_IMP(a_high_cnt, clk, arst_n, phase_q == PH_TRIG_HIGH, phase_ticks_q != '0, "pulse counter zero in high phase")
	`UER_ASSERT_NXT(a_stay_idle, clk, arst_n, adv && phase_q == PH_IDLE && !start_req, phase_q == PH_IDLE, "left idle without start")

endmodule

FILE: rtl/core/uer_queue.sv
// ---------------------------------------------------------------------------
// uer_queue
// Short FIFO of command words between the sequencer and the back end.
// ---------------------------------------------------------------------------
module uer_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  uer_pkg::uer_cmd_t wr_data,
	output logic              full,
	output logic              rd_valid,
	input  logic              rd_en,
	output uer_pkg::uer_cmd_t rd_data
);
	import uer_pkg::*;

	uer_cmd_t             entry_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 do_wr, do_rd;

	assign full     = (count_q == QCNT_BITS'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = entry_q[rd_ptr_q];
	assign do_wr    = wr_en & ~full;
	assign do_rd    = rd_en & rd_valid;

	// store word
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QCNT_BITS'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QCNT_BITS'(1);
			end
		end
	end

endmodule

FILE: rtl/core/uer_back.sv
// ---------------------------------------------------------------------------
// uer_back
// Distance conversion, last-distance hold and the result queue.
// ---------------------------------------------------------------------------
module uer_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  uer_pkg::uer_cmd_t cmd,
	output logic              cmd_pop,
	output logic              empty,
	input  logic              pop,
	output uer_pkg::uer_res_t res
);
	import uer_pkg::*;

	logic                  valid_s1;
	uer_cmd_t              cmd_s1;
	logic [PROD_BITS-1:0]  prod_s1;
	logic [DIST_BITS-1:0]  last_dist_q;
	logic [DIST_BITS-1:0]  dist_new;
	logic                  adv_s1;
	uer_res_t              res_new;
	uer_res_t              oq_q [OQ_DEPTH];
	logic [OQPTR_BITS-1:0] oq_wr_q, oq_rd_q;
	logic [OQCNT_BITS-1:0] oq_cnt_q;
	logic                  oq_full, oq_rd;

	assign oq_full = (oq_cnt_q == OQCNT_BITS'(OQ_DEPTH));
	assign adv_s1  = valid_s1 & ~oq_full;
	assign cmd_pop = cmd_valid & (~valid_s1 | adv_s1);
	assign empty   = (oq_cnt_q == '0);
	assign oq_rd   = pop & ~empty;
	assign res     = oq_q[oq_rd_q];

	// multiply by the reciprocal of 58
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_s1  <= cmd;
			prod_s1 <= PROD_BITS'(cmd.ticks) * PROD_BITS'(DIV_MUL);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_pop) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// pick the distance shown with this word
	always_comb begin
		if (cmd_s1.upd) begin
			dist_new = sat_dist(prod_s1[PROD_BITS-1:DIV_SHIFT]);
		end else if (cmd_s1.tmo) begin
			dist_new = '0;
		end else begin
			dist_new = last_dist_q;
		end
		res_new.trig    = cmd_s1.trig;
		res_new.busy    = cmd_s1.busy;
		res_new.done    = cmd_s1.done;
		res_new.tmo     = cmd_s1.tmo;
		res_new.dist_cm = dist_new;
	end

	// hold last distance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_dist_q <= '0;
		end else if (adv_s1) begin
			last_dist_q <= dist_new;
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			oq_q[oq_wr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (adv_s1) begin
				oq_wr_q <= oq_wr_q + OQPTR_BITS'(1);
			end
			if (oq_rd) begin
				oq_rd_q <= oq_rd_q + OQPTR_BITS'(1);
			end
			if (adv_s1 && !oq_rd) begin
				oq_cnt_q <= oq_cnt_q + OQCNT_BITS'(1);
			end else if (oq_rd && !adv_s1) begin
				oq_cnt_q <= oq_cnt_q - OQCNT_BITS'(1);
			end
		end
	end

endmodule

FILE: rtl/core/ultrasonic_echo_ranger.sv
// ---------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Ultrasonic range controller stepped by one-microsecond tick words.
// ---------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | push / full        | start_req, echo_level
//  result   | pop / empty        | trigger_level, busy_res, done_res,
//           |                    | timed_out, distance_cm
//  config   | cfg_we             | cfg_index, cfg_data
//
//  One tick word is taken per clock while full is low; the sequencer steps once
//  per accepted word. A result passes from the command queue through the
//  reciprocal multiply stage into the result queue.
//  Reset clears the sequencer, both queues and the held distance; the
//  registers return to 8, 20, 5000 and 29000.
//  A stalled result side fills the result queue, then the command queue, then
//  raises full; each side stalls independently.
// ---------------------------------------------------------------------------
module ultrasonic_echo_ranger (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              start_req,
	input  logic                              echo_level,
	output logic                              empty,
	input  logic                              pop,
	output logic                              trigger_level,
	output logic                              busy_res,
	output logic                              done_res,
	output logic                              timed_out,
	output logic [uer_pkg::DIST_BITS-1:0]     distance_cm,
	input  logic                              cfg_we,
	input  logic [uer_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [uer_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import uer_pkg::*;

	logic     accept;
	logic     cmd_wr;
	uer_cmd_t cmd_in, cmd_out;
	logic     cmd_valid, cmd_pop;
	uer_res_t res;

	assign accept = push & ~full;

	uer_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (accept),
		.start_req  (start_req),
		.echo_level (echo_level),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd_valid  (cmd_wr),
		.cmd        (cmd_in)
	);

	uer_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd_wr),
		.wr_data  (cmd_in),
		.full     (full),
		.rd_valid (cmd_valid),
		.rd_en    (cmd_pop),
		.rd_data  (cmd_out)
	);

	uer_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	// unpack the result word
	assign trigger_level = res.trig;
	assign busy_res      = res.busy;
	assign done_res      = res.done;
	assign timed_out     = res.tmo;
	assign distance_cm   = res.dist_cm;

endmodule
